[design/bsa_pkg.sv]
package bsa_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 31;
  localparam int unsigned TYPE_W = 2;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned IDXO_W = 7;

  // Bitmap memory word: 32 slots per entry
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  localparam logic [TYPE_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_RESIZE = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_NONE   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_GRANTED    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_PASS       = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FREED      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_IN_POOL = 3'd4;
  localparam logic [STAT_W-1:0] STAT_KEPT       = 3'd5;
  localparam logic [STAT_W-1:0] STAT_MOVE       = 3'd6;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } scan_res_t;

endpackage

[design/bsa_bitmap_ram.sv]
module bsa_bitmap_ram #(
  parameter int unsigned WORDS = 4,
  parameter int unsigned WA_W  = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [WA_W-1:0]           rd_addr_i,
  output logic [bsa_pkg::WORD_W-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [WA_W-1:0]           wr_addr_i,
  input  logic [bsa_pkg::WORD_W-1:0] wr_data_i
);
  import bsa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic [WORDS-1:0]  vld_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // An entry never written reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rdata_q : '0;

endmodule

[design/bsa_word_scan.sv]
module bsa_word_scan (
  input  logic [bsa_pkg::WORD_W-1:0] word_i,
  input  logic [bsa_pkg::WORD_W-1:0] valid_mask_i,
  input  logic [bsa_pkg::BIT_W-1:0]  off_i,
  input  logic                       first_i,
  input  logic                       last_i,
  output bsa_pkg::scan_res_t         scan_o
);
  import bsa_pkg::*;

  logic [WORD_W-1:0] cand;

  // First pass takes bits at or above the pointer, the wrap pass those below it
  always_comb begin
    for (int unsigned b = 0; b < WORD_W; b++) begin
      cand[b] = ~word_i[b] & valid_mask_i[b]
              & (!first_i || (BIT_W'(b) >= off_i))
              & (!last_i  || (BIT_W'(b) <  off_i));
    end
  end

  always_comb begin
    scan_o.found = |cand;
    scan_o.pos   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        scan_o.pos = BIT_W'(b);
      end
    end
  end

endmodule

[design/bitmap_slot_allocator_next_fit_unit.sv]
// Allocate searches the bitmap one memory word per cycle, starting at the search pointer's word
// and wrapping round to it again; the other requests do no search.
// Throughput: one request at a time; busy_o is high until its result strobe has been issued.
// The receiver cannot stall: each result is shown for one cycle with result_valid_o.
// Reset: every slot free, search pointer and pool_base zero; usage words read as zero
// until first written, so no clearing pass is needed.
module bitmap_slot_allocator_next_fit_unit #(
  parameter int unsigned SLOT_COUNT = 128,
  parameter int unsigned SLOT_SHIFT = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [bsa_pkg::TYPE_W-1:0] req_type_i,
  input  logic [bsa_pkg::SIZE_W-1:0] req_size_i,
  input  logic [bsa_pkg::ADDR_W-1:0] block_address_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bsa_pkg::ADDR_W-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output logic [bsa_pkg::STAT_W-1:0] status_o,
  output logic [bsa_pkg::ADDR_W-1:0] slot_address_o,
  output logic [bsa_pkg::IDXO_W-1:0] slot_index_o
);
  import bsa_pkg::*;

  localparam int unsigned IDX_W     = $clog2(SLOT_COUNT);
  localparam int unsigned WORDS     = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PE_W      = WA_W + BIT_W;
  localparam int unsigned PASS_W    = $clog2(WORDS + 1);
  localparam int unsigned LAST_BITS = SLOT_COUNT - (WORDS - 1) * WORD_W;
  localparam int unsigned IHI_W     = ADDR_W - SLOT_SHIFT;
  localparam logic [WORD_W-1:0] LAST_MASK  = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
  localparam logic [SIZE_W-1:0] SLOT_BYTES = SIZE_W'(1) << SLOT_SHIFT;
  localparam logic [WA_W-1:0]   LAST_WORD  = WA_W'(WORDS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_GRANT,
    S_CLR_RD,
    S_CLR_WR
  } state_e;

  state_e            state_q, state_d;
  logic [TYPE_W-1:0] req_type_q, req_type_d;
  logic [SIZE_W-1:0] req_size_q, req_size_d;
  logic [ADDR_W-1:0] req_addr_q, req_addr_d;
  logic [ADDR_W-1:0] pool_base_q, pool_base_d;
  logic [IDX_W-1:0]  search_start_q, search_start_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [WA_W-1:0]   scan_word_q, scan_word_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic              res_valid_q, res_valid_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [IDXO_W-1:0] res_idx_q, res_idx_d;

  logic              rd_en, wr_en;
  logic [WA_W-1:0]   rd_addr, wr_addr;
  logic [WORD_W-1:0] rd_data, wr_data;

  logic [PE_W-1:0]   ptr_ext, slot_ext, found_ext;
  logic [WA_W-1:0]   ptr_word, slot_word, next_word;
  logic [BIT_W-1:0]  ptr_off, slot_bit;
  logic [ADDR_W:0]   diff;
  logic              in_pool;
  logic [IDX_W-1:0]  loc_slot, found_slot;
  logic [IDX_W:0]    ptr_sum;
  logic [IDX_W-1:0]  ptr_next;
  logic [WORD_W-1:0] valid_mask;
  logic              first_pass, last_pass;
  scan_res_t         scan;

  function automatic logic [IDXO_W-1:0] idx_out(input logic [IDX_W-1:0] s);
    logic [IDX_W+IDXO_W-1:0] e;
    e = (IDX_W + IDXO_W)'(s);
    return e[IDXO_W-1:0];
  endfunction

  bsa_bitmap_ram #(
    .WORDS (WORDS),
    .WA_W  (WA_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  bsa_word_scan u_scan (
    .word_i       (rd_data),
    .valid_mask_i (valid_mask),
    .off_i        (ptr_off),
    .first_i      (first_pass),
    .last_i       (last_pass),
    .scan_o       (scan)
  );

  always_comb begin
    ptr_ext    = PE_W'(search_start_q);
    ptr_word   = ptr_ext[PE_W-1:BIT_W];
    ptr_off    = ptr_ext[BIT_W-1:0];
    slot_ext   = PE_W'(slot_q);
    slot_word  = slot_ext[PE_W-1:BIT_W];
    slot_bit   = slot_ext[BIT_W-1:0];
    next_word  = (scan_word_q == LAST_WORD) ? '0 : scan_word_q + WA_W'(1);
    // Borrow out of the subtract flags an address below the pool
    diff       = {1'b0, req_addr_q} - {1'b0, pool_base_q};
    in_pool    = !diff[ADDR_W] && (diff[ADDR_W-1:SLOT_SHIFT] < IHI_W'(SLOT_COUNT));
    loc_slot   = diff[SLOT_SHIFT +: IDX_W];
    found_ext  = {scan_word_q, scan.pos};
    found_slot = found_ext[IDX_W-1:0];
    ptr_sum    = (IDX_W + 1)'(found_slot) + (IDX_W + 1)'(1);
    ptr_next   = (ptr_sum == (IDX_W + 1)'(SLOT_COUNT)) ? '0 : ptr_sum[IDX_W-1:0];
    valid_mask = (scan_word_q == LAST_WORD) ? LAST_MASK : '1;
    first_pass = (pass_q == '0);
    last_pass  = (pass_q == PASS_W'(WORDS));
  end

  always_comb begin
    state_d        = state_q;
    req_type_d     = req_type_q;
    req_size_d     = req_size_q;
    req_addr_d     = req_addr_q;
    pool_base_d    = pool_base_q;
    search_start_d = search_start_q;
    slot_d         = slot_q;
    scan_word_d    = scan_word_q;
    pass_d         = pass_q;
    res_valid_d    = 1'b0;
    res_status_d   = res_status_q;
    res_addr_d     = res_addr_q;
    res_idx_d      = res_idx_q;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      pool_base_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_type_d = req_type_i;
          req_size_d = req_size_i;
          req_addr_d = block_address_i;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (req_type_q) inside
          REQ_ALLOC: begin
            if (req_size_q == SLOT_BYTES) begin
              rd_en       = 1'b1;
              rd_addr     = ptr_word;
              scan_word_d = ptr_word;
              pass_d      = '0;
              state_d     = S_SCAN;
            end else begin
              res_valid_d  = 1'b1;
              res_status_d = STAT_PASS;
              res_addr_d   = '0;
              res_idx_d    = '0;
              state_d      = S_IDLE;
            end
          end
          REQ_FREE, REQ_RESIZE: begin
            slot_d = loc_slot;
            if (!in_pool) begin
              res_valid_d  = 1'b1;
              res_status_d = STAT_NOT_IN_POOL;
              res_addr_d   = '0;
              res_idx_d    = '0;
              state_d      = S_IDLE;
            end else if (req_type_q == REQ_RESIZE && req_size_q <= SLOT_BYTES) begin
              res_valid_d  = 1'b1;
              res_status_d = STAT_KEPT;
              res_addr_d   = req_addr_q;
              res_idx_d    = idx_out(loc_slot);
              state_d      = S_IDLE;
            end else begin
              state_d = S_CLR_RD;
            end
          end
          default: begin
            res_valid_d  = 1'b1;
            res_status_d = STAT_PASS;
            res_addr_d   = '0;
            res_idx_d    = '0;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (scan.found) begin
          wr_en          = 1'b1;
          wr_addr        = scan_word_q;
          wr_data        = rd_data | (WORD_W'(1) << scan.pos);
          slot_d         = found_slot;
          search_start_d = ptr_next;
          state_d        = S_GRANT;
        end else if (last_pass) begin
          res_valid_d  = 1'b1;
          res_status_d = STAT_FULL;
          res_addr_d   = '0;
          res_idx_d    = '0;
          state_d      = S_IDLE;
        end else begin
          // Fetch the next word while this one is checked
          rd_en       = 1'b1;
          rd_addr     = next_word;
          scan_word_d = next_word;
          pass_d      = pass_q + PASS_W'(1);
        end
      end
      S_GRANT: begin
        res_valid_d  = 1'b1;
        res_status_d = STAT_GRANTED;
        res_addr_d   = pool_base_q + (ADDR_W'(slot_q) << SLOT_SHIFT);
        res_idx_d    = idx_out(slot_q);
        state_d      = S_IDLE;
      end
      S_CLR_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot_word;
        state_d = S_CLR_WR;
      end
      S_CLR_WR: begin
        wr_en        = 1'b1;
        wr_addr      = slot_word;
        wr_data      = rd_data & ~(WORD_W'(1) << slot_bit);
        res_valid_d  = 1'b1;
        res_status_d = (req_type_q == REQ_FREE) ? STAT_FREED : STAT_MOVE;
        res_addr_d   = '0;
        res_idx_d    = idx_out(slot_q);
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      req_type_q     <= '0;
      req_size_q     <= '0;
      req_addr_q     <= '0;
      pool_base_q    <= '0;
      search_start_q <= '0;
      slot_q         <= '0;
      scan_word_q    <= '0;
      pass_q         <= '0;
      res_valid_q    <= 1'b0;
      res_status_q   <= '0;
      res_addr_q     <= '0;
      res_idx_q      <= '0;
    end else begin
      state_q        <= state_d;
      req_type_q     <= req_type_d;
      req_size_q     <= req_size_d;
      req_addr_q     <= req_addr_d;
      pool_base_q    <= pool_base_d;
      search_start_q <= search_start_d;
      slot_q         <= slot_d;
      scan_word_q    <= scan_word_d;
      pass_q         <= pass_d;
      res_valid_q    <= res_valid_d;
      res_status_q   <= res_status_d;
      res_addr_q     <= res_addr_d;
      res_idx_q      <= res_idx_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign slot_address_o = res_addr_q;
  assign slot_index_o   = res_idx_q;

endmodule
